@@ rtl/core/acd_pkg.sv @@
// Shared types, codes and per-byte digest functions for the stream digest block.
package acd_pkg;

  localparam int unsigned OffW = 63;

  localparam logic [16:0] AdlerMod  = 17'd65521;
  localparam logic [31:0] AdlerInit = 32'h0000_0001;
  localparam logic [31:0] CrcPoly   = 32'h82F6_3B78;
  localparam logic [7:0]  StateVer  = 8'd1;

  typedef enum logic [1:0] {
    MODE_DATA    = 2'd0,
    MODE_CLOSE   = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUT_ORDER = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_MARK_MISS = 3'd3,
    ST_IGNORED   = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [OffW-1:0] byte_offset;
    logic [7:0]      data_byte;
    logic [7:0]      restore_version;
    logic [31:0]     restore_adler;
    logic [OffW-1:0] restore_epoch_start;
    logic [31:0]     restore_crc;
    logic [OffW-1:0] watermark;
  } dig_in_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [31:0]     adler_value;
    logic [OffW-1:0] epoch_offset;
    logic [OffW-1:0] epoch_length;
    logic [31:0]     closed_crc;
    logic [OffW-1:0] covered_bytes;
    logic            poisoned_flag;
  } dig_out_t;

  // s2 may start above the modulus after a restore, so s2 + s1 needs two trims
  function automatic logic [31:0] adler_step(input logic [31:0] a, input logic [7:0] b);
    logic [16:0] t1;
    logic [16:0] s1n;
    logic [16:0] t2;
    logic [16:0] u;
    logic [16:0] s2n;
    t1  = {1'b0, a[15:0]} + {9'd0, b};
    s1n = (t1 >= AdlerMod) ? (t1 - AdlerMod) : t1;
    t2  = {1'b0, a[31:16]} + s1n;
    u   = (t2 >= AdlerMod) ? (t2 - AdlerMod) : t2;
    s2n = (u >= AdlerMod) ? (u - AdlerMod) : u;
    return {s2n[15:0], s1n[15:0]};
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

endpackage

@@ rtl/core/acd_if.sv @@
// Valid/ready channel interfaces for input words and result words.
interface acd_in_if;
  logic             valid;
  logic             ready;
  acd_pkg::dig_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acd_out_if;
  logic              valid;
  logic              ready;
  acd_pkg::dig_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/acd_in_stage.sv @@
// Input register: holds one accepted word until the digest core takes it.
module acd_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  acd_in_if.sink           in_if,
  input  logic             item_take,
  output logic             item_valid,
  output acd_pkg::dig_in_t item
);
  import acd_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  dig_in_t item_r;

  // refill in the same cycle the held word leaves
  assign in_if.ready = !valid_r || item_take;
  assign valid_nxt   = (in_if.valid && in_if.ready) || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_if.valid && in_if.ready) begin
      item_r <= in_if.data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

@@ rtl/core/acd_core.sv @@
// Digest state, per-word update and result register.
module acd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  input  acd_pkg::dig_in_t item,
  output logic             item_take,
  acd_out_if.source        out_if
);
  import acd_pkg::*;

  logic [OffW-1:0] covered_r,  covered_nxt;
  logic [31:0]     adler_r,    adler_nxt;
  logic [OffW-1:0] start_r,    start_nxt;
  logic [31:0]     crc_r,      crc_nxt;
  logic            poison_r,   poison_nxt;
  logic            out_valid_r;
  dig_out_t        out_r,      out_nxt;

  assign item_take = item_valid && (!out_valid_r || out_if.ready);

  always_comb begin
    covered_nxt = covered_r;
    adler_nxt   = adler_r;
    start_nxt   = start_r;
    crc_nxt     = crc_r;
    poison_nxt  = poison_r;
    out_nxt     = '0;
    out_nxt.status = ST_OK;

    case (mode_t'(item.mode))
      MODE_DATA: begin
        // offset check wins even when already poisoned
        if (item.byte_offset != covered_r) begin
          poison_nxt     = 1'b1;
          out_nxt.status = ST_OUT_ORDER;
        end else if (poison_r) begin
          out_nxt.status = ST_IGNORED;
        end else begin
          adler_nxt   = adler_step(adler_r, item.data_byte);
          crc_nxt     = crc_step(crc_r, item.data_byte);
          covered_nxt = covered_r + OffW'(1);
        end
      end
      MODE_CLOSE: begin
        out_nxt.epoch_offset = start_r;
        out_nxt.epoch_length = covered_r - start_r;
        out_nxt.closed_crc   = crc_r;
        start_nxt            = covered_r;
        crc_nxt              = '0;
      end
      MODE_RESTORE: begin
        if (item.restore_version != StateVer) begin
          out_nxt.status = ST_BAD_VER;
        end else if (item.byte_offset != item.watermark ||
                     item.restore_epoch_start != item.byte_offset) begin
          out_nxt.status = ST_MARK_MISS;
        end else begin
          covered_nxt = item.byte_offset;
          adler_nxt   = item.restore_adler;
          start_nxt   = item.restore_epoch_start;
          crc_nxt     = item.restore_crc;
          poison_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase

    out_nxt.adler_value   = adler_nxt;
    out_nxt.covered_bytes = covered_nxt;
    out_nxt.poisoned_flag = poison_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      covered_r   <= '0;
      adler_r     <= AdlerInit;
      start_r     <= '0;
      crc_r       <= '0;
      poison_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_take) begin
        covered_r <= covered_nxt;
        adler_r   <= adler_nxt;
        start_r   <= start_nxt;
        crc_r     <= crc_nxt;
        poison_r  <= poison_nxt;
      end
      if (item_take) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (item_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;
endmodule

@@ rtl/core/adler32_crc32c_epoch_digest.sv @@
// Stream digest top: running Adler-32 over the stream and CRC-32C per epoch.
// Path: an accepted word is held in the input register, and the result register
// then takes its result word. Throughput: one word per cycle while out_if is not
// stalled; the state update is combinational between the two registers.
// Reset: synchronous active-low rst_n; covered 0, adler 1, epoch start 0,
// epoch CRC 0, not poisoned, both registers empty.
module adler32_crc32c_epoch_digest (
  input  logic      clk,
  input  logic      rst_n,
  acd_in_if.sink    in_if,
  acd_out_if.source out_if
);
  import acd_pkg::*;

  logic    item_valid;
  logic    item_take;
  dig_in_t item;

  acd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .item_take  (item_take),
    .item_valid (item_valid),
    .item       (item)
  );

  acd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .out_if     (out_if)
  );
endmodule
